// ----- design/b32d_pkg.sv -----
// ----------------------------------------------------------------------------
// b32d_pkg: shared types and constants of the base32 block decoder
// Job record handed from the character front end to the result back end,
// result codes and queue sizing.
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam int GROUP_W     = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

    // One job covers every result caused by a single input item.
    typedef struct packed {
        logic [GROUP_W-1:0] bits;       // bytes to send, first in the top byte
        logic [2:0]         nbytes;     // 0..5 data bytes
        logic               has_status; // status item follows the bytes
        logic [1:0]         status;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- design/b32d_front.sv -----
// ----------------------------------------------------------------------------
// b32d_front: character front end
// Maps each character to its 5-bit value, packs groups and builds one job
// per item that causes output.
// ----------------------------------------------------------------------------
module b32d_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept_i,
    input  logic [7:0]           char_code_i,
    input  logic                 last_char_i,
    output logic                 push_o,
    output b32d_pkg::job_t       job_o
);

    logic [b32d_pkg::GROUP_W-1:0] group_reg, group_next;
    logic [2:0]                   cnt_reg, cnt_next;
    logic                         bad_reg, bad_next;

    logic [5:0]                   sym;
    logic                         bad_upd;
    logic [b32d_pkg::GROUP_W-1:0] grp_shift;
    logic [2:0]                   cnt_inc;
    logic                         full_grp;
    b32d_pkg::job_t               job;

    // bit 5 flags a character outside the alphabet
    function automatic logic [5:0] map_char(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h61 && c <= 8'h7a) begin
                d = c - 8'h61;
                map_char = {1'b0, d[4:0]};
            end else if (c >= 8'h32 && c <= 8'h37) begin
                d = c - 8'h32 + 8'h1a;
                map_char = {1'b0, d[4:0]};
            end else begin
                map_char = 6'b100000;
            end
        end
    endfunction

    always_comb begin
        sym       = map_char(char_code_i);
        bad_upd   = bad_reg | sym[5];
        grp_shift = {group_reg[b32d_pkg::GROUP_W-6:0], sym[4:0]};
        cnt_inc   = cnt_reg + 3'd1;
        full_grp  = (cnt_inc == 3'd0);

        job = '0;
        if (full_grp && !bad_upd) begin
            job.bits   = grp_shift;
            job.nbytes = 3'd5;
        end
        if (last_char_i) begin
            job.has_status = 1'b1;
            unique case (cnt_inc) inside
                3'd1, 3'd3, 3'd6: job.status = b32d_pkg::STATUS_BAD_LEN;
                default: begin
                    if (bad_upd) begin
                        job.status = b32d_pkg::STATUS_BAD_CHAR;
                    end else begin
                        job.status = b32d_pkg::STATUS_OK;
                        // partial group: pad with zeros up to 40 bits
                        unique case (cnt_inc)
                            3'd2: begin
                                job.bits   = grp_shift << 30;
                                job.nbytes = 3'd1;
                            end
                            3'd4: begin
                                job.bits   = grp_shift << 20;
                                job.nbytes = 3'd2;
                            end
                            3'd5: begin
                                job.bits   = grp_shift << 15;
                                job.nbytes = 3'd3;
                            end
                            3'd7: begin
                                job.bits   = grp_shift << 5;
                                job.nbytes = 3'd4;
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end

        group_next = group_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        if (accept_i) begin
            if (last_char_i) begin
                group_next = '0;
                cnt_next   = 3'd0;
                bad_next   = 1'b0;
            end else begin
                group_next = full_grp ? '0 : grp_shift;
                cnt_next   = cnt_inc;
                bad_next   = bad_upd;
            end
        end
    end

    assign push_o = accept_i && (job.nbytes != 3'd0 || job.has_status);
    assign job_o  = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg <= '0;
            cnt_reg   <= 3'd0;
            bad_reg   <= 1'b0;
        end else begin
            group_reg <= group_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

// ----- design/b32d_queue.sv -----
// ----------------------------------------------------------------------------
// b32d_queue: job queue
// Short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module b32d_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_i,
    input  b32d_pkg::job_t       job_i,
    input  logic                 pop_i,
    output b32d_pkg::job_t       job_o,
    output b32d_pkg::q_stat_t    stat_o
);

    b32d_pkg::job_t             mem_reg [b32d_pkg::QUEUE_DEPTH];
    logic [b32d_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [b32d_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [b32d_pkg::QCNT_W-1:0] count_reg, count_next;

    function automatic logic [b32d_pkg::QPTR_W-1:0] ptr_inc(
        input logic [b32d_pkg::QPTR_W-1:0] p);
        begin
            if (p == b32d_pkg::QPTR_W'(b32d_pkg::QUEUE_DEPTH - 1))
                ptr_inc = '0;
            else
                ptr_inc = p + b32d_pkg::QPTR_W'(1);
        end
    endfunction

    always_comb begin
        wr_ptr_next = push_i ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop_i  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_i && !pop_i)
            count_next = count_reg + b32d_pkg::QCNT_W'(1);
        else if (pop_i && !push_i)
            count_next = count_reg - b32d_pkg::QCNT_W'(1);
    end

    assign job_o        = mem_reg[rd_ptr_reg];
    assign stat_o.full  = (count_reg == b32d_pkg::QCNT_W'(b32d_pkg::QUEUE_DEPTH));
    assign stat_o.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push_i)
            mem_reg[wr_ptr_reg] <= job_i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !stat_o.full || pop_i)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_i |-> !stat_o.empty)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= b32d_pkg::QCNT_W'(b32d_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- design/b32d_back.sv -----
// ----------------------------------------------------------------------------
// b32d_back: result back end
// Takes jobs from the queue and sends their data bytes and status item
// one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module b32d_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  b32d_pkg::job_t       job_i,
    input  b32d_pkg::q_stat_t    q_stat_i,
    output logic                 pop_o,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [7:0]           m_data_byte,
    output logic [1:0]           m_status,
    output logic                 m_last_of_run
);

    logic                          busy_reg, busy_next;
    logic [b32d_pkg::GROUP_W-1:0]  bits_reg, bits_next;
    logic [2:0]                    left_reg, left_next;
    logic                          has_status_reg, has_status_next;
    logic [1:0]                    status_reg, status_next;

    logic is_data;
    logic is_final;
    logic load;

    always_comb begin
        is_data  = (left_reg != 3'd0);
        is_final = !is_data || (left_reg == 3'd1 && !has_status_reg);
        load     = !q_stat_i.empty && (!busy_reg || (m_ready && is_final));

        busy_next       = busy_reg;
        bits_next       = bits_reg;
        left_next       = left_reg;
        has_status_next = has_status_reg;
        status_next     = status_reg;
        if (load) begin
            busy_next       = 1'b1;
            bits_next       = job_i.bits;
            left_next       = job_i.nbytes;
            has_status_next = job_i.has_status;
            status_next     = job_i.status;
        end else if (busy_reg && m_ready) begin
            if (is_final) begin
                busy_next = 1'b0;
            end else begin
                bits_next = bits_reg << 8;
                left_next = left_reg - 3'd1;
            end
        end
    end

    assign pop_o         = load;
    assign m_valid       = busy_reg;
    assign m_kind        = is_data ? b32d_pkg::KIND_DATA : b32d_pkg::KIND_STATUS;
    assign m_data_byte   = is_data ? bits_reg[b32d_pkg::GROUP_W-1 -: 8] : 8'h00;
    assign m_status      = is_data ? b32d_pkg::STATUS_OK : status_reg;
    assign m_last_of_run = is_final;

    always_ff @(posedge aclk) begin
        bits_reg       <= bits_next;
        left_reg       <= left_next;
        has_status_reg <= has_status_next;
        status_reg     <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    a_status_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == b32d_pkg::KIND_STATUS |-> m_last_of_run && m_data_byte == 8'h00)
        else $error("status item not closing its run");

    a_data_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == b32d_pkg::KIND_DATA |-> m_status == b32d_pkg::STATUS_OK)
        else $error("data item with non-zero status");

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> left_reg <= 3'd5)
        else $error("byte count out of range");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_o && busy_reg |-> m_ready && m_last_of_run)
        else $error("job loaded over an unfinished one");

endmodule

// ----- design/base32_block_decoder_top.sv -----
// ----------------------------------------------------------------------------
// base32_block_decoder_top: streaming base32 decoder
// Lowercase unpadded alphabet, five bytes per eight characters.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (s_*): one character per item, s_last_char on the final
//   character of a message. Output channel (m_*): data bytes (m_kind 0),
//   then one status item (m_kind 1) per message; m_last_of_run marks the
//   final result caused by one input item.
//   Path: an accepted item's job is written into the job queue, loaded
//   into the back end's registers at the head and presented from there.
//   Throughput: one character per cycle and one result per cycle while
//   the queue has room and m_ready is high. The front end takes a character
//   every cycle while the job queue (QUEUE_DEPTH jobs) has room; the back end
//   sends one item per cycle while m_ready is high, five for a full group.
//   When m_ready is low the back end holds its current item, the queue
//   fills and s_ready drops once it is full.
//   Reset (aresetn low, synchronous) empties the queue, drops m_valid and
//   starts a new message.
// ----------------------------------------------------------------------------
module base32_block_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_data_byte,
    output logic [1:0]  m_status,
    output logic        m_last_of_run
);

    b32d_pkg::job_t    push_job;
    b32d_pkg::job_t    head_job;
    b32d_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;
    logic              accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    b32d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept_i    (accept),
        .char_code_i (s_char_code),
        .last_char_i (s_last_char),
        .push_o      (push),
        .job_o       (push_job)
    );

    b32d_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .job_i   (push_job),
        .pop_i   (pop),
        .job_o   (head_job),
        .stat_o  (q_stat)
    );

    b32d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_i         (head_job),
        .q_stat_i      (q_stat),
        .pop_o         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

endmodule
